@@ sv/evtv_pkg.sv @@
// Shared types and constants for the EEVDF virtual-time accounting block.
// No dependencies; imported by every module of the block.
`default_nettype none
package evtv_pkg;

   localparam int unsigned SLICE_NS_DEF = 20000000;
   localparam int unsigned CAP_SCALE    = 1024;
   localparam int unsigned PCT_SCALE    = 100;
   localparam int unsigned BIG_PCT      = 90;
   localparam int unsigned LAG_SHIFT    = 2;     // quantum / 4
   localparam int unsigned INV_BITS     = 20;
   localparam int unsigned CAP_SHIFT    = 10;    // divide by CAP_SCALE

   localparam int unsigned VT_W   = 64;
   localparam int unsigned SUM_W  = 40;
   localparam int unsigned WT_W   = 14;
   localparam int unsigned CAP_W  = 11;
   localparam int unsigned SL_W   = 25;
   localparam int unsigned USED_W = 27;          // holds SLICE_NS up to its maximum
   localparam int unsigned Q_W    = 28;          // quantum
   localparam int unsigned WV_W   = 35;          // quantum*100 or scaled service
   localparam int unsigned INV_W  = 21;
   localparam int unsigned FIFO_DEPTH = 2;

   localparam logic [WV_W-1:0]  LOW32   = WV_W'(64'hffff_ffff);
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   typedef enum logic [2:0] {
      CMD_ENQUEUE    = 3'd0,
      CMD_RUNNING    = 3'd1,
      CMD_STOPPING   = 3'd2,
      CMD_SET_WEIGHT = 3'd3,
      CMD_ENABLE     = 3'd4,
      CMD_DISABLE    = 3'd5
   } cmd_type;

   // item after classification: zero weights/capacity replaced, service time computed
   typedef struct packed {
      logic [2:0]        cmd;
      logic [VT_W-1:0]   tv;
      logic [WT_W-1:0]   w;
      logic [WT_W-1:0]   nw;
      logic [USED_W-1:0] used;
      logic [CAP_W-1:0]  cap;
   } item_type;

   typedef struct packed {
      logic [VT_W-1:0]  tv;
      logic [VT_W-1:0]  vd;
      logic             qc;
      logic [VT_W-1:0]  g;
      logic [SUM_W-1:0] ws;
   } res_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

endpackage
`default_nettype wire

@@ sv/evtv_front.sv @@
// Front end: accepts event words, normalizes their fields and queues them.
// Depends on evtv_pkg.
`default_nettype none
module evtv_front import evtv_pkg::*; #(
   parameter int unsigned SLICE_NS = SLICE_NS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire logic [2:0]         command,
   input  wire logic [VT_W-1:0]    task_vtime,
   input  wire logic [WT_W-1:0]    task_weight,
   input  wire logic [WT_W-1:0]    next_weight,
   input  wire logic [SL_W-1:0]    slice_left,
   input  wire logic [CAP_W-1:0]   cpu_cap,
   output fifo_stat_type           stat,
   output item_type                item,
   output logic                    item_valid,
   input  wire logic               item_take
);

   localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

   item_type             mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   item_type             cls;
   logic [USED_W-1:0]    sl_ext;
   logic                 do_push;

   assign sl_ext = USED_W'(slice_left);

   always_comb begin
      cls.cmd  = command;
      cls.tv   = task_vtime;
      cls.w    = (task_weight == '0) ? WT_W'(1) : task_weight;
      cls.nw   = (next_weight == '0) ? WT_W'(1) : next_weight;
      cls.cap  = (cpu_cap == '0) ? CAP_W'(CAP_SCALE) : cpu_cap;
      // overrun of the slice charges nothing
      cls.used = (sl_ext > USED_W'(SLICE_NS)) ? '0 : USED_W'(SLICE_NS) - sl_ext;
   end

   assign stat.full  = (count_ff == CNT_W'(FIFO_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign item_valid = !stat.empty;
   assign item       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !stat.full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (item_take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, item_take})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

@@ sv/evtv_div.sv @@
// Radix-2 restoring divider: 64-bit dividend by 40-bit divisor, one bit a cycle.
// Depends on evtv_pkg.
`default_nettype none
module evtv_div import evtv_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [VT_W-1:0]   dividend,
   input  wire logic [SUM_W-1:0]  divisor,
   output logic                   done,
   output logic [VT_W-1:0]        quotient
);

   localparam int unsigned CNT_W = $clog2(VT_W);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [VT_W-1:0]     quo_ff;
   logic [SUM_W-1:0]    rem_ff;
   logic [SUM_W-1:0]    den_ff;
   logic [SUM_W:0]      trial;
   logic                fits;

   assign trial    = {rem_ff, quo_ff[VT_W-1]};
   assign fits     = (trial >= {1'b0, den_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract where it fits
         rem_ff <= fits ? SUM_W'(trial - {1'b0, den_ff}) : trial[SUM_W-1:0];
         quo_ff <= {quo_ff[VT_W-2:0], fits};
      end
   end

endmodule
`default_nettype wire

@@ sv/evtv_back.sv @@
// Back end: sequencer that carries out one queued event against the global
// time and weight sum, sharing one divider. Depends on evtv_pkg and evtv_div.
`default_nettype none
module evtv_back import evtv_pkg::*; #(
   parameter int unsigned SLICE_NS = SLICE_NS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [CAP_W-1:0]  max_cap,
   input  item_type               item,
   input  wire logic              item_valid,
   output logic                   item_take,
   output res_type                res,
   output logic                   res_valid,
   input  wire logic              res_ready
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_STP_M2, ST_WD_INV, ST_WD_SEL, ST_WD_MUL, ST_WD_DIV,
      ST_ENQ_FIN, ST_STP_TV, ST_STP_G, ST_LAGMAG, ST_SW_D1, ST_SW_D2, ST_SW_ABS,
      ST_DIV_ADJ, ST_ADJ
   } state_type;

   localparam int unsigned MC_W  = CAP_W + 1;
   localparam int unsigned QM_W  = MC_W + USED_W;
   localparam int unsigned M1_W  = USED_W + CAP_W;
   localparam int unsigned M2_W  = M1_W + 7;
   localparam int unsigned PR_W  = 32 + INV_W;
   localparam int unsigned PC_W  = MC_W + 7;

   state_type          st_ff;
   item_type           it_ff;
   logic [VT_W-1:0]    tv_ff, vd_ff, g_ff;
   logic               qc_ff, big_ff;
   logic [SUM_W-1:0]   ws_ff, oldsum_ff;
   logic [MC_W-1:0]    mc_ff;
   logic [Q_W-1:0]     q_ff, boost_ff;
   logic [WV_W-1:0]    wd_val_ff;
   logic [VT_W-1:0]    minv_ff, lag_ff, lag_mag_ff, q1_ff, d_ff, adj_mag_ff, wd_res_ff;
   logic               lag_neg_ff, adj_neg_ff;
   logic [INV_W-1:0]   inv_ff;
   logic [PR_W-1:0]    prod_ff;
   logic [M1_W-1:0]    m1_ff;
   logic               div_go_ff;
   logic [VT_W-1:0]    div_num_ff;
   logic [SUM_W-1:0]   div_den_ff;
   logic               adj_seen_ff;

   logic               div_done;
   logic [VT_W-1:0]    div_quo;
   logic [VT_W-1:0]    sq;          // signed quotient from the divider
   logic [VT_W-1:0]    dd_clamp, dd_run, t_en, lag_abs, d_abs, lag_e;
   logic [SUM_W:0]     sw_sum, en_sum;
   logic [SUM_W-1:0]   sw_sub, sw_new, en_new, dis_new;
   logic [M2_W-1:0]    m2;
   logic [SUM_W-1:0]   wext;

   evtv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (div_num_ff),
      .divisor  (div_den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign item_take = (st_ff == ST_IDLE) && item_valid;
   assign res_valid = (st_ff == ST_ADJ) && adj_seen_ff;
   assign wext      = SUM_W'(it_ff.w);

   always_comb begin
      sq       = lag_neg_ff ? (VT_W'(0) - div_quo) : div_quo;
      dd_clamp = it_ff.tv - minv_ff;
      dd_run   = g_ff - it_ff.tv;
      t_en     = (it_ff.tv == '0) ? g_ff : it_ff.tv;
      lag_e    = lag_ff;
      lag_abs  = lag_e[VT_W-1] ? (VT_W'(0) - lag_e) : lag_e;
      d_abs    = d_ff[VT_W-1] ? (VT_W'(0) - d_ff) : d_ff;
      sw_sub   = (ws_ff >= wext) ? ws_ff - wext : ws_ff;
      sw_sum   = {1'b0, sw_sub} + (SUM_W + 1)'(it_ff.nw);
      sw_new   = sw_sum[SUM_W] ? SUM_MAX : sw_sum[SUM_W-1:0];
      en_sum   = {1'b0, ws_ff} + (SUM_W + 1)'(it_ff.w);
      en_new   = en_sum[SUM_W] ? SUM_MAX : en_sum[SUM_W-1:0];
      dis_new  = (ws_ff >= wext) ? ws_ff - wext : '0;
      m2       = M2_W'(m1_ff) * M2_W'(PCT_SCALE);
   end

   // quantum and its derived bounds follow the capacity register
   always_ff @(posedge clock) begin
      mc_ff    <= (max_cap == '0) ? MC_W'(CAP_SCALE) : MC_W'(max_cap);
      q_ff     <= Q_W'((QM_W'(mc_ff) * QM_W'(SLICE_NS)) >> CAP_SHIFT);
      boost_ff <= (q_ff >> LAG_SHIFT) + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         g_ff      <= '0;
         ws_ff     <= '0;
         div_go_ff <= 1'b0;
      end else begin
         div_go_ff <= 1'b0;
         unique case (st_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  it_ff <= item;
                  st_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               tv_ff <= it_ff.tv;
               vd_ff <= '0;
               qc_ff <= 1'b0;
               case (it_ff.cmd)
                  CMD_ENQUEUE: begin
                     minv_ff   <= (g_ff > VT_W'(q_ff)) ? g_ff - VT_W'(q_ff) : '0;
                     big_ff    <= (PC_W'(it_ff.cap) * PC_W'(PCT_SCALE)) >=
                                  (PC_W'(mc_ff) * PC_W'(BIG_PCT));
                     wd_val_ff <= WV_W'(q_ff) * WV_W'(PCT_SCALE);
                     st_ff     <= ST_STP_M2;
                  end
                  CMD_RUNNING: begin
                     if (dd_run[VT_W-1]) begin
                        g_ff <= it_ff.tv;
                     end
                     st_ff <= ST_ADJ;
                     adj_neg_ff <= 1'b0;
                     adj_mag_ff <= '0;
                  end
                  CMD_STOPPING: begin
                     m1_ff <= M1_W'(it_ff.used) * M1_W'(it_ff.cap);
                     st_ff <= ST_STP_M2;
                  end
                  CMD_SET_WEIGHT: begin
                     oldsum_ff <= ws_ff;
                     ws_ff     <= sw_new;
                     lag_ff    <= g_ff - it_ff.tv;
                     st_ff     <= ST_LAGMAG;
                  end
                  CMD_ENABLE: begin
                     tv_ff  <= t_en;
                     lag_ff <= g_ff - t_en;
                     ws_ff  <= en_new;
                     st_ff  <= ST_LAGMAG;
                  end
                  CMD_DISABLE: begin
                     lag_ff <= g_ff - it_ff.tv;
                     ws_ff  <= dis_new;
                     st_ff  <= ST_LAGMAG;
                  end
                  default: begin
                     adj_neg_ff <= 1'b0;
                     adj_mag_ff <= '0;
                     st_ff      <= ST_ADJ;
                  end
               endcase
            end
            ST_STP_M2: begin
               // scaled service for stop; enqueue already holds quantum*100
               if (it_ff.cmd == CMD_STOPPING) begin
                  wd_val_ff <= WV_W'(m2 >> CAP_SHIFT);
               end
               div_go_ff  <= 1'b1;
               div_num_ff <= VT_W'((INV_W'(1) << INV_BITS) + INV_W'(it_ff.w >> 1));
               div_den_ff <= wext;
               st_ff      <= ST_WD_INV;
            end
            ST_WD_INV: begin
               if (it_ff.cmd == CMD_ENQUEUE && dd_clamp[VT_W-1]) begin
                  tv_ff <= minv_ff;
               end
               if (div_done) begin
                  inv_ff <= (div_quo == '0) ? INV_W'(1) : div_quo[INV_W-1:0];
                  st_ff  <= ST_WD_SEL;
               end
            end
            ST_WD_SEL: begin
               lag_ff <= g_ff - tv_ff;
               if (wd_val_ff <= LOW32) begin
                  prod_ff <= PR_W'(wd_val_ff[31:0]) * PR_W'(inv_ff);
                  st_ff   <= ST_WD_MUL;
               end else begin
                  div_go_ff  <= 1'b1;
                  div_num_ff <= VT_W'(wd_val_ff);
                  div_den_ff <= wext;
                  st_ff      <= ST_WD_DIV;
               end
            end
            ST_WD_MUL: begin
               wd_res_ff <= VT_W'(prod_ff >> INV_BITS);
               st_ff     <= (it_ff.cmd == CMD_ENQUEUE) ? ST_ENQ_FIN : ST_STP_TV;
            end
            ST_WD_DIV: begin
               if (div_done) begin
                  wd_res_ff <= div_quo;
                  st_ff     <= (it_ff.cmd == CMD_ENQUEUE) ? ST_ENQ_FIN : ST_STP_TV;
               end
            end
            ST_ENQ_FIN: begin
               vd_ff <= tv_ff + wd_res_ff;
               if (!lag_ff[VT_W-1] && lag_abs > VT_W'(boost_ff)) begin
                  qc_ff <= 1'b0;
               end else if (lag_ff[VT_W-1] && lag_abs > VT_W'(boost_ff)) begin
                  qc_ff <= 1'b1;
               end else begin
                  qc_ff <= !big_ff;
               end
               adj_neg_ff <= 1'b0;
               adj_mag_ff <= '0;
               st_ff      <= ST_ADJ;
            end
            ST_STP_TV: begin
               tv_ff <= tv_ff + wd_res_ff;
               adj_neg_ff <= 1'b0;
               adj_mag_ff <= '0;
               if (ws_ff != '0) begin
                  div_go_ff  <= 1'b1;
                  div_num_ff <= VT_W'(wd_val_ff);
                  div_den_ff <= ws_ff;
                  st_ff      <= ST_STP_G;
               end else begin
                  st_ff <= ST_ADJ;
               end
            end
            ST_STP_G: begin
               // stop charge wraps, no saturation
               if (div_done) begin
                  g_ff  <= g_ff + div_quo;
                  st_ff <= ST_ADJ;
               end
            end
            ST_LAGMAG: begin
               lag_neg_ff <= lag_ff[VT_W-1];
               lag_mag_ff <= lag_abs;
               adj_neg_ff <= 1'b0;
               adj_mag_ff <= '0;
               div_num_ff <= lag_abs;
               case (it_ff.cmd)
                  CMD_SET_WEIGHT: begin
                     div_den_ff <= oldsum_ff;
                     if (oldsum_ff != '0 && ws_ff != '0) begin
                        div_go_ff <= 1'b1;
                        st_ff     <= ST_SW_D1;
                     end else begin
                        st_ff <= ST_ADJ;
                     end
                  end
                  default: begin
                     div_den_ff <= ws_ff;
                     if (ws_ff != '0) begin
                        div_go_ff <= 1'b1;
                        st_ff     <= ST_DIV_ADJ;
                     end else begin
                        st_ff <= ST_ADJ;
                     end
                  end
               endcase
            end
            ST_SW_D1: begin
               if (div_done) begin
                  q1_ff      <= sq;
                  div_go_ff  <= 1'b1;
                  div_num_ff <= lag_mag_ff;
                  div_den_ff <= ws_ff;
                  st_ff      <= ST_SW_D2;
               end
            end
            ST_SW_D2: begin
               if (div_done) begin
                  d_ff  <= q1_ff - sq;
                  st_ff <= ST_SW_ABS;
               end
            end
            ST_SW_ABS: begin
               adj_neg_ff <= d_ff[VT_W-1];
               adj_mag_ff <= d_abs;
               st_ff      <= ST_ADJ;
            end
            ST_DIV_ADJ: begin
               if (div_done) begin
                  // enable subtracts the quotient, disable adds it
                  adj_neg_ff <= (it_ff.cmd == CMD_ENABLE) ? !lag_neg_ff : lag_neg_ff;
                  adj_mag_ff <= div_quo;
                  st_ff      <= ST_ADJ;
               end
            end
            ST_ADJ: begin
               // saturating move of global time, then hold the result until taken
               if (!adj_neg_ff) begin
                  g_ff <= (g_ff > ~adj_mag_ff) ? '1 : g_ff + adj_mag_ff;
               end else begin
                  g_ff <= (g_ff > adj_mag_ff) ? g_ff - adj_mag_ff : '0;
               end
               adj_neg_ff <= 1'b0;
               adj_mag_ff <= '0;
               if (res_valid && res_ready) begin
                  st_ff <= ST_IDLE;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   // offer the result once global time has settled, from the cycle after ST_ADJ is entered
   always_ff @(posedge clock) begin
      if (reset) begin
         adj_seen_ff <= 1'b0;
      end else if (st_ff == ST_ADJ && !adj_seen_ff) begin
         adj_seen_ff <= 1'b1;
      end else if (res_valid && res_ready) begin
         adj_seen_ff <= 1'b0;
      end
   end

   assign res.tv = tv_ff;
   assign res.vd = vd_ff;
   assign res.qc = qc_ff;
   assign res.g  = g_ff;
   assign res.ws = ws_ff;

endmodule
`default_nettype wire

@@ sv/eevdf_vtime_accounting.sv @@
// Top level of the EEVDF virtual-time accounting block: capacity register,
// front queue, back sequencer and result register. Depends on evtv_pkg, evtv_front, evtv_back and evtv_div.
//
//   channel   handshake                  payload
//   req       push / full                command .. cpu_cap
//   rsp       empty / pop                updated_task_vtime .. active_weight
//   csr       csr_valid / csr_ready      csr_max_capacity
//
// The shared divider retires one quotient bit a cycle. Running needs no divide;
// enqueue, enable and disable need one; stopping and set weight need two (when a
// weight sum is zero, stopping needs one and disable and set weight none). A weighted
// value above 32 bits adds another divide to enqueue and stopping.
// Reset is synchronous; global time and weight sum clear to zero, capacity to 1024.
// The front queue holds two words, and one finished result waits in the output
// register, so pushes continue while the result side stalls until the queue is full.
`default_nettype none
module eevdf_vtime_accounting import evtv_pkg::*; #(
   parameter int unsigned SLICE_NS = SLICE_NS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic [2:0]         req_command,
   input  wire logic [VT_W-1:0]    req_task_vtime,
   input  wire logic [WT_W-1:0]    req_task_weight,
   input  wire logic [WT_W-1:0]    req_next_weight,
   input  wire logic [SL_W-1:0]    req_slice_left,
   input  wire logic [CAP_W-1:0]   req_cpu_cap,
   output logic                    empty,
   input  wire logic               pop,
   output logic [VT_W-1:0]         rsp_updated_task_vtime,
   output logic [VT_W-1:0]         rsp_virtual_deadline,
   output logic                    rsp_queue_class,
   output logic [VT_W-1:0]         rsp_global_vtime,
   output logic [SUM_W-1:0]        rsp_active_weight,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CAP_W-1:0]   csr_max_capacity
);

   logic [CAP_W-1:0] max_cap_ff;
   fifo_stat_type    fe_stat;
   item_type         fe_item;
   logic             fe_valid, fe_take;
   res_type          bk_res, rsp_ff;
   logic             bk_res_valid, bk_res_ready;
   logic             rsp_valid_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_cap_ff <= CAP_W'(CAP_SCALE);
      end else if (csr_valid && csr_ready) begin
         max_cap_ff <= csr_max_capacity;
      end
   end

   evtv_front #(.SLICE_NS(SLICE_NS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .command      (req_command),
      .task_vtime   (req_task_vtime),
      .task_weight  (req_task_weight),
      .next_weight  (req_next_weight),
      .slice_left   (req_slice_left),
      .cpu_cap      (req_cpu_cap),
      .stat         (fe_stat),
      .item         (fe_item),
      .item_valid   (fe_valid),
      .item_take    (fe_take)
   );

   evtv_back #(.SLICE_NS(SLICE_NS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .max_cap    (max_cap_ff),
      .item       (fe_item),
      .item_valid (fe_valid),
      .item_take  (fe_take),
      .res        (bk_res),
      .res_valid  (bk_res_valid),
      .res_ready  (bk_res_ready)
   );

   assign full         = fe_stat.full;
   assign bk_res_ready = !rsp_valid_ff || pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (bk_res_valid && bk_res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (bk_res_valid && bk_res_ready) begin
         rsp_ff <= bk_res;
      end
   end

   assign empty                  = !rsp_valid_ff;
   assign rsp_updated_task_vtime = rsp_ff.tv;
   assign rsp_virtual_deadline   = rsp_ff.vd;
   assign rsp_queue_class        = rsp_ff.qc;
   assign rsp_global_vtime       = rsp_ff.g;
   assign rsp_active_weight      = rsp_ff.ws;

   a_push_kept: assert property (@(posedge clock) disable iff (reset)
      push && !full |=> !fe_stat.empty)
      else $error("accepted word not held in front queue");

   a_rsp_from_back: assert property (@(posedge clock) disable iff (reset)
      $fell(empty) |-> $past(bk_res_valid))
      else $error("result register loaded without an offered result");

   a_back_holds: assert property (@(posedge clock) disable iff (reset)
      bk_res_valid && !bk_res_ready |=> bk_res_valid)
      else $error("back end dropped an untaken result");

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Testbench for eevdf_vtime_accounting: drives scheduler events through the request
// queue, predicts each result word in a local model and compares it field by field.
// Depends on evtv_pkg and the eevdf_vtime_accounting RTL.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import evtv_pkg::*;

   localparam longint unsigned SLICE = 20000000;
   localparam longint unsigned TOP = 64'h8000_0000_0000_0000;
   localparam longint unsigned SMAX = 64'h00ff_ffff_ffff;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic [2:0] req_command = '0;
   logic [VT_W-1:0] req_task_vtime = '0;
   logic [WT_W-1:0] req_task_weight = '0;
   logic [WT_W-1:0] req_next_weight = '0;
   logic [SL_W-1:0] req_slice_left = '0;
   logic [CAP_W-1:0] req_cpu_cap = '0;
   logic empty;
   logic pop = 1'b0;
   logic [VT_W-1:0] rsp_updated_task_vtime, rsp_virtual_deadline, rsp_global_vtime;
   logic rsp_queue_class;
   logic [SUM_W-1:0] rsp_active_weight;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CAP_W-1:0] csr_max_capacity = '0;

   eevdf_vtime_accounting dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // model state
   longint unsigned mdl_cap = 1024, mdl_gvt = 0, mdl_wsum = 0;
   res_type expected_words[$];
   int send_idle_pct = 0, recv_idle_pct = 0;
   int mismatches = 0, idle_cycles = 0;
   bit timed_out = 0;

   function automatic bit earlier(longint unsigned a, longint unsigned b);
      return ((a - b) & TOP) != 0;
   endfunction

   function automatic longint unsigned div_by_weight(longint unsigned v, longint unsigned w);
      longint unsigned inv;
      inv = ((64'd1 << 20) + w / 2) / w;
      if (inv == 0) inv = 1;
      if (v <= 64'hffff_ffff) return (v * inv) >> 20;
      return v / w;
   endfunction

   function automatic longint unsigned signed_quot(longint unsigned n, longint unsigned d);
      bit neg;
      longint unsigned q;
      neg = (n & TOP) != 0;
      if (d == 0) return 0;
      q = (neg ? -n : n) / d;
      return neg ? -q : q;
   endfunction

   function automatic void shift_gvt(bit neg, longint unsigned mag);
      if (!neg) mdl_gvt = (mdl_gvt > ~64'd0 - mag) ? ~64'd0 : mdl_gvt + mag;
      else mdl_gvt = (mdl_gvt > mag) ? mdl_gvt - mag : 0;
   endfunction

   function automatic void shift_gvt_signed(longint unsigned d);
      shift_gvt((d & TOP) != 0, ((d & TOP) != 0) ? -d : d);
   endfunction

   function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
      return (a + b > SMAX) ? SMAX : a + b;
   endfunction

   function automatic res_type account_event(logic [2:0] cmd, longint unsigned tv,
         longint unsigned w, longint unsigned nw, longint unsigned sl, longint unsigned cap);
      res_type r;
      longint unsigned mc, qn, vd, minv, boost, lag, mag, used, svc, old_sum, d;
      bit qc, neg;
      mc = mdl_cap ? mdl_cap : 1024;
      qn = mc * SLICE / 1024;
      vd = 0;
      qc = 0;
      if (w == 0) w = 1;
      if (nw == 0) nw = 1;
      if (cap == 0) cap = 1024;
      case (cmd)
         CMD_ENQUEUE: begin
            minv = mdl_gvt > qn ? mdl_gvt - qn : 0;
            boost = qn / 4 + 1;
            if (earlier(tv, minv)) tv = minv;
            vd = tv + div_by_weight(qn * 100, w);
            lag = mdl_gvt - tv;
            neg = (lag & TOP) != 0;
            mag = neg ? -lag : lag;
            if (mag > boost) qc = neg;
            else qc = (cap * 100 >= mc * 90) ? 0 : 1;
         end
         CMD_RUNNING: begin
            if (earlier(mdl_gvt, tv)) mdl_gvt = tv;
         end
         CMD_STOPPING: begin
            used = sl > SLICE ? 0 : SLICE - sl;
            svc = used * cap * 100 / 1024;
            tv += div_by_weight(svc, w);
            if (mdl_wsum != 0) mdl_gvt += svc / mdl_wsum;
         end
         CMD_SET_WEIGHT: begin
            old_sum = mdl_wsum;
            if (mdl_wsum >= w) mdl_wsum -= w;
            mdl_wsum = sat_sum(mdl_wsum, nw);
            if (old_sum != 0 && mdl_wsum != 0) begin
               lag = mdl_gvt - tv;
               shift_gvt_signed(signed_quot(lag, old_sum) - signed_quot(lag, mdl_wsum));
            end
         end
         CMD_ENABLE: begin
            if (tv == 0) tv = mdl_gvt;
            lag = mdl_gvt - tv;
            old_sum = sat_sum(mdl_wsum, w);
            d = signed_quot(lag, old_sum);
            neg = (d & TOP) != 0;
            // subtract the quotient: flip its direction
            shift_gvt(!neg, neg ? -d : d);
            mdl_wsum = old_sum;
         end
         CMD_DISABLE: begin
            lag = mdl_gvt - tv;
            mdl_wsum = mdl_wsum >= w ? mdl_wsum - w : 0;
            if (mdl_wsum != 0) shift_gvt_signed(signed_quot(lag, mdl_wsum));
         end
         default: ;
      endcase
      r.tv = tv;
      r.vd = vd;
      r.qc = qc;
      r.g = mdl_gvt;
      r.ws = mdl_wsum[SUM_W-1:0];
      return r;
   endfunction

   // hold push high across back-to-back words; drop it only when the sender idles
   task automatic send_word(logic [2:0] cmd, logic [63:0] tv, logic [13:0] w,
         logic [13:0] nw, logic [24:0] sl, logic [10:0] cap);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_command <= cmd;
      req_task_vtime <= tv;
      req_task_weight <= w;
      req_next_weight <= nw;
      req_slice_left <= sl;
      req_cpu_cap <= cap;
      do @(posedge clock); while (full);
      expected_words.push_back(account_event(cmd, tv, w, nw, sl, cap));
   endtask

   task automatic drain;
      push <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (160) @(posedge clock);
   endtask

   task automatic write_capacity(logic [10:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_max_capacity <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mdl_cap = value;
   endtask

   // receiver: pop at random, check every accepted word against the oldest prediction
   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word");
            end else begin
               want = expected_words.pop_front();
               if (rsp_updated_task_vtime !== want.tv || rsp_virtual_deadline !== want.vd ||
                     rsp_queue_class !== want.qc || rsp_global_vtime !== want.g ||
                     rsp_active_weight !== want.ws) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp tv=%h vd=%h qc=%b g=%h ws=%h got %h %h %b %h %h",
                        want.tv, want.vd, want.qc, want.g, want.ws, rsp_updated_task_vtime,
                        rsp_virtual_deadline, rsp_queue_class, rsp_global_vtime,
                        rsp_active_weight);
               end
            end
         end
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: count cycles without any handshake
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT)
         timed_out <= 1'b1;
      else
         idle_cycles <= idle_cycles + 1;
   end

   function automatic logic [63:0] rand_vtime();
      case ($urandom_range(3))
         0: return {$urandom, $urandom};
         1: return mdl_gvt + 64'($urandom_range(40000000)) - 64'd20000000;
         2: return {32'd0, $urandom};
         default: return mdl_gvt;
      endcase
   endfunction

   function automatic logic [13:0] rand_weight();
      return ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(10000));
   endfunction

   task automatic test_directed;
      send_word(CMD_ENABLE, 64'd0, 14'd0, 14'd0, 25'd0, 11'd0);
      send_word(CMD_ENABLE, 64'd5, 14'd10000, 14'd0, 25'd0, 11'd1024);
      send_word(CMD_ENQUEUE, 64'd0, 14'd0, 14'd0, 25'd0, 11'd0);
      send_word(CMD_ENQUEUE, '1, 14'd10000, 14'd0, 25'd0, 11'd1);
      send_word(CMD_ENQUEUE, 64'h7fff_ffff_ffff_ffff, 14'd1, 14'd0, 25'd0, 11'd921);
      send_word(CMD_RUNNING, 64'd50000000, 14'd1, 14'd1, 25'd0, 11'd0);
      send_word(CMD_ENQUEUE, 64'd50000000, 14'd3, 14'd0, 25'd0, 11'd922);
      send_word(CMD_ENQUEUE, 64'd1, 14'd16383, 14'd0, 25'd0, 11'd2047);
      send_word(CMD_STOPPING, 64'd100, 14'd0, 14'd0, 25'd0, 11'd0);
      send_word(CMD_STOPPING, '1, 14'd1, 14'd0, 25'd20000000, 11'd1024);
      send_word(CMD_STOPPING, 64'd7, 14'd16383, 14'd0, 25'h1ffffff, 11'd2047);
      send_word(CMD_SET_WEIGHT, 64'd0, 14'd0, 14'd16383, 25'd0, 11'd0);
      send_word(CMD_SET_WEIGHT, '1, 14'd16383, 14'd0, 25'd0, 11'd0);
      send_word(CMD_DISABLE, 64'h8000_0000_0000_0000, 14'd1, 14'd0, 25'd0, 11'd0);
      send_word(CMD_DISABLE, 64'd0, 14'd16383, 14'd0, 25'd0, 11'd0);
      send_word(CMD_SET_WEIGHT, 64'd1, 14'd5, 14'd5, 25'd0, 11'd0);
      send_word(CMD_ENABLE, '1, 14'd16383, 14'd0, 25'd0, 11'd0);
      send_word(CMD_RUNNING, '1, 14'd0, 14'd0, 25'd0, 11'd0);
      send_word(CMD_ENQUEUE, 64'd0, 14'd1, 14'd0, 25'd0, 11'd0);
      send_word(3'd6, 64'h1234, 14'd1, 14'd1, 25'd1, 11'd1);
      send_word(3'd7, '1, '1, '1, '1, '1);
   endtask

   task automatic test_random(int count);
      logic [2:0] cmd;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 20) cmd = CMD_ENQUEUE;
         else if (pick < 35) cmd = CMD_RUNNING;
         else if (pick < 55) cmd = CMD_STOPPING;
         else if (pick < 70) cmd = CMD_SET_WEIGHT;
         else if (pick < 83) cmd = CMD_ENABLE;
         else if (pick < 96) cmd = CMD_DISABLE;
         else cmd = 3'($urandom_range(7));
         send_word(cmd, rand_vtime(), rand_weight(), rand_weight(),
            ($urandom_range(9) == 0) ? 25'($urandom) : 25'($urandom_range(20000000)),
            ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(1024)));
      end
   endtask

   task automatic test_capacity_settings;
      write_capacity(11'd0);
      test_random(100);
      write_capacity(11'd2047);
      test_random(100);
      write_capacity(11'd1);
      test_random(100);
      write_capacity(11'd512);
      test_random(100);
      write_capacity(11'd1024);
   endtask

   task automatic test_idle_patterns;
      send_idle_pct = 22; recv_idle_pct = 69;
      test_random(170);
      send_idle_pct = 69; recv_idle_pct = 22;
      test_random(170);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(170);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_capacity_settings();
      test_idle_patterns();
      drain();
      if (mismatches == 0 && expected_words.size() == 0)
         $display("PASS eevdf_vtime_accounting");
      else
         $display("FAIL eevdf_vtime_accounting");
      $finish;
   end

   initial begin
      wait (timed_out);
      $display("FAIL eevdf_vtime_accounting");
      $finish;
   end
endmodule
`default_nettype wire
